// ----- sv/sphere_mesh_subdivider_top_assert.svh -----
// Assertion macros for the checker file.
`ifndef SPHERE_MESH_SUBDIVIDER_TOP_ASSERT_SVH
`define SPHERE_MESH_SUBDIVIDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMSUB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMSUB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/smsub_pkg.sv -----
package smsub_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int EDGE_SLOTS   = 6;
    localparam int FRAC_BITS    = 16;

    localparam int IDX_W      = 12;
    localparam int CRD_W      = 18;
    localparam int SUM_W      = CRD_W + 1;
    localparam int STORE_CAP  = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
    localparam int ADDR_W     = $clog2(STORE_CAP);
    localparam int NV_W       = ADDR_W + 1;
    localparam int SLOT_W     = $clog2(EDGE_SLOTS);

    localparam int GUARD_BITS = 12;
    localparam int NUM_SHIFT  = FRAC_BITS + GUARD_BITS + 1;
    localparam int DIVD_W     = SUM_W + NUM_SHIFT + 1;
    localparam int Q_W        = (FRAC_BITS + 4 > CRD_W + 1) ? FRAC_BITS + 4 : CRD_W + 1;
    localparam int R_W        = 32;
    localparam int REM_W      = R_W + 2;
    localparam int N2_W       = 2 * SUM_W + 2;
    localparam int RAD_W      = 63;
    localparam int RAD_SHIFT  = 24;
    localparam int SQRT_ITERS = 32;
    localparam int CNT_W      = $clog2(SQRT_ITERS);

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;
    localparam int USER_W      = 2;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_TRI   = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_VTX = 2'd0,
        KIND_TRI = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SLOTS = 2'd1,
        ERR_STORE = 2'd2
    } err_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ERD_A,
        S_ERD_B,
        S_ELAT,
        S_EVAL,
        S_VRD_A,
        S_VRD_B,
        S_VLAT,
        S_NSTART,
        S_NWAIT,
        S_WR_A,
        S_WR_B,
        S_EMIT_V,
        S_NEXT,
        S_EMIT_T,
        S_ERR_SLOT,
        S_ERR_STORE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] nb;
        logic [IDX_W-1:0] mid;
    } slot_t;

    typedef slot_t [EDGE_SLOTS-1:0] row_t;

    typedef struct packed {
        logic  load_wr;
        logic  tri_cap;
        logic  nv_reset;
        logic  clr_start;
        logic  clr_step;
        logic  sel_b;
        logic  er_rd;
        logic  er_lat_a;
        logic  er_lat_b;
        logic  take_mid;
        logic  alloc;
        logic  vr_rd;
        logic  vr_lat_a;
        logic  vr_lat_b;
        logic  norm_start;
        logic  row_wr;
        logic  edge_next;
        logic  out_load;
        kind_t out_kind;
        err_t  out_err;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad_corner;
        logic found;
        logic store_full;
        logic slots_full;
        logic norm_done;
        logic out_free;
        logic edge_last;
        logic tri_last;
    } stat_t;

endpackage

// ----- sv/smsub_norm.sv -----
module smsub_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [smsub_pkg::SUM_W-1:0] sx,
    input  logic signed [smsub_pkg::SUM_W-1:0] sy,
    input  logic signed [smsub_pkg::SUM_W-1:0] sz,
    output logic                               done,
    output logic signed [smsub_pkg::CRD_W-1:0] x,
    output logic signed [smsub_pkg::CRD_W-1:0] y,
    output logic signed [smsub_pkg::CRD_W-1:0] z
);
    import smsub_pkg::*;

    norm_state_t st_reg, st_next;

    logic [SUM_W-1:0]         mag_reg [3];
    logic [2:0]               neg_reg;
    logic [2*SUM_W-1:0]       prod_reg;
    logic [N2_W-1:0]          acc_reg;
    logic [RAD_W-1:0]         rad_reg, res_reg, bit_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               crd_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [Q_W-1:0]           low_reg, q_reg;
    logic signed [CRD_W-1:0]  out_reg [3];

    logic [SUM_W-1:0]  sq_src, dv_src;
    logic [N2_W-1:0]   acc_sum;
    logic [RAD_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  dvs, shl;
    logic              dtake;
    logic [Q_W-1:0]    q_nxt;
    logic [DIVD_W-1:0] divd;

    function automatic logic [SUM_W-1:0] abs_sum(logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    function automatic logic signed [CRD_W-1:0] sat_coord(logic [Q_W-1:0] q, logic neg);
        logic signed [CRD_W-1:0] r;
        r = '0;
        if (q >= Q_W'(1 << (CRD_W - 1)))
        begin
            r = neg ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
        end
        else
        begin
            r = neg ? -$signed(CRD_W'(q)) : $signed(CRD_W'(q));
        end
        return r;
    endfunction

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_src = mag_reg[0];
            2'd1:    sq_src = mag_reg[1];
            2'd2:    sq_src = mag_reg[2];
            default: sq_src = '0;
        endcase
        case (crd_reg)
            2'd0:    dv_src = mag_reg[0];
            2'd1:    dv_src = mag_reg[1];
            2'd2:    dv_src = mag_reg[2];
            default: dv_src = '0;
        endcase
    end

    assign acc_sum = acc_reg + N2_W'(prod_reg);
    assign trial   = res_reg + bit_reg;
    assign take    = rad_reg >= trial;
    assign dvs     = REM_W'({res_reg[R_W-1:0], 1'b0});
    assign shl     = {rem_reg[REM_W-2:0], low_reg[Q_W-1]};
    assign dtake   = shl >= dvs;
    assign q_nxt   = {q_reg[Q_W-2:0], dtake};
    assign divd    = (DIVD_W'(dv_src) << NUM_SHIFT) + DIVD_W'(res_reg[R_W-1:0]);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            N_IDLE:  if (start) st_next = N_SQ;
            N_SQ:
            begin
                if (cnt_reg == CNT_W'(3))
                begin
                    st_next = (acc_sum == '0) ? N_DONE : N_SQRT;
                end
            end
            N_SQRT:  if (cnt_reg == '0) st_next = N_DLOAD;
            N_DLOAD: st_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = (crd_reg == 2'd2) ? N_DONE : N_DLOAD;
                end
            end
            N_DONE:  st_next = N_IDLE;
            default: st_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= N_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            N_IDLE:
            begin
                mag_reg[0] <= abs_sum(sx);
                mag_reg[1] <= abs_sum(sy);
                mag_reg[2] <= abs_sum(sz);
                neg_reg    <= {sz[SUM_W-1], sy[SUM_W-1], sx[SUM_W-1]};
                prod_reg   <= '0;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            N_SQ:
            begin
                // one square per cycle, registered before it is summed
                prod_reg <= sq_src * sq_src;
                acc_reg  <= acc_sum;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    rad_reg    <= RAD_W'(acc_sum) << RAD_SHIFT;
                    res_reg    <= '0;
                    bit_reg    <= RAD_W'(1) << (2 * (SQRT_ITERS - 1));
                    cnt_reg    <= CNT_W'(SQRT_ITERS - 1);
                    crd_reg    <= '0;
                    out_reg[0] <= '0;
                    out_reg[1] <= '0;
                    out_reg[2] <= '0;
                end
            end
            N_SQRT:
            begin
                if (take)
                begin
                    rad_reg <= rad_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
            N_DLOAD:
            begin
                rem_reg <= REM_W'(divd >> Q_W);
                low_reg <= divd[Q_W-1:0];
                q_reg   <= '0;
                cnt_reg <= CNT_W'(Q_W - 1);
            end
            N_DIV:
            begin
                rem_reg <= dtake ? shl - dvs : shl;
                low_reg <= low_reg << 1;
                q_reg   <= q_nxt;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    case (crd_reg)
                        2'd0:    out_reg[0] <= sat_coord(q_nxt, neg_reg[0]);
                        2'd1:    out_reg[1] <= sat_coord(q_nxt, neg_reg[1]);
                        default: out_reg[2] <= sat_coord(q_nxt, neg_reg[2]);
                    endcase
                    crd_reg <= crd_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign done = (st_reg == N_DONE);
    assign x    = out_reg[0];
    assign y    = out_reg[1];
    assign z    = out_reg[2];

endmodule

// ----- sv/smsub_dp.sv -----
module smsub_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  smsub_pkg::cmd_t                      cmd,
    output smsub_pkg::stat_t                     stat,
    input  logic [smsub_pkg::IN_TDATA_W-1:0]     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [smsub_pkg::OUT_TDATA_W-1:0]    out_data,
    output logic [smsub_pkg::USER_W-1:0]         out_user,
    output logic                                 out_last
);
    import smsub_pkg::*;

    // input fields
    logic [IDX_W-1:0] ld_index, in_ca, in_cb, in_cc;
    logic [CRD_W-1:0] ld_x, ld_y, ld_z;
    logic             ld_ok;

    assign ld_index = in_data[11:0];
    assign ld_x     = in_data[29:12];
    assign ld_y     = in_data[47:30];
    assign ld_z     = in_data[65:48];
    assign in_ca    = in_data[77:66];
    assign in_cb    = in_data[89:78];
    assign in_cc    = in_data[101:90];
    assign ld_ok    = (ld_index != '0) && (NV_W'(ld_index) < NV_W'(STORE_CAP));

    // storage
    row_t               emem [STORE_CAP];
    logic [3*CRD_W-1:0] vmem [STORE_CAP];
    row_t               erd_reg;
    logic [3*CRD_W-1:0] vrd_reg;

    logic [IDX_W-1:0]   corner_reg [3];
    logic [IDX_W-1:0]   mid_reg [3];
    logic [1:0]         edge_cnt_reg, tri_cnt_reg;
    logic [NV_W-1:0]    nv_reg;
    logic [ADDR_W-1:0]  n_reg, clr_cnt_reg;
    logic [SLOT_W-1:0]  fa_reg, fb_reg;
    row_t               row_a_reg, row_b_reg;
    logic [3*CRD_W-1:0] va_reg, vb_reg;

    logic                    out_valid_reg, out_last_reg;
    kind_t                   out_kind_reg;
    err_t                    out_err_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [CRD_W-1:0]        out_x_reg, out_y_reg, out_z_reg;
    logic [IDX_W-1:0]        out_ta_reg, out_tb_reg, out_tc_reg;

    logic [IDX_W-1:0]        end_a, end_b, end_sel;
    logic [IDX_W:0]          hit;
    logic [SLOT_W:0]         fa, fb;
    row_t                    new_row_a, new_row_b;
    logic                    norm_done;
    logic signed [CRD_W-1:0] nx, ny, nz;
    logic signed [SUM_W-1:0] sx, sy, sz;
    logic [IDX_W-1:0]        tri_a, tri_b, tri_c;
    logic                    out_free;

    function automatic logic [IDX_W:0] edge_find(row_t ra, row_t rb,
                                                 logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        logic [IDX_W:0] f;
        f = '0;
        for (int i = 0; i < EDGE_SLOTS; i++)
        begin
            if (ra[i].nb == b)
            begin
                f = {1'b1, ra[i].mid};
            end
            else if (rb[i].nb == a)
            begin
                f = {1'b1, rb[i].mid};
            end
        end
        return f;
    endfunction

    function automatic logic [SLOT_W:0] first_free(row_t r, logic skip_en,
                                                   logic [SLOT_W-1:0] skip);
        logic [SLOT_W:0] f;
        f = '0;
        for (int i = 0; i < EDGE_SLOTS; i++)
        begin
            if (!f[SLOT_W] && (r[i].nb == '0) && !(skip_en && (SLOT_W'(i) == skip)))
            begin
                f = {1'b1, SLOT_W'(i)};
            end
        end
        return f;
    endfunction

    function automatic row_t set_slot(row_t r, logic [SLOT_W-1:0] idx,
                                      logic [IDX_W-1:0] nb, logic [IDX_W-1:0] mid);
        row_t o;
        o          = r;
        o[idx].nb  = nb;
        o[idx].mid = mid;
        return o;
    endfunction

    // edge endpoints in the order the sub-triangles first need them: AB, CA, BC
    always_comb
    begin
        case (edge_cnt_reg)
            2'd0:
            begin
                end_a = corner_reg[0];
                end_b = corner_reg[1];
            end
            2'd1:
            begin
                end_a = corner_reg[2];
                end_b = corner_reg[0];
            end
            default:
            begin
                end_a = corner_reg[1];
                end_b = corner_reg[2];
            end
        endcase
    end

    assign end_sel   = cmd.sel_b ? end_b : end_a;
    assign hit       = edge_find(row_a_reg, row_b_reg, end_a, end_b);
    assign fa        = first_free(row_a_reg, 1'b0, '0);
    assign fb        = first_free(row_b_reg, end_a == end_b, fa[SLOT_W-1:0]);
    assign new_row_a = set_slot(row_a_reg, fa_reg, end_b, IDX_W'(n_reg));
    assign new_row_b = set_slot((end_a == end_b) ? new_row_a : row_b_reg, fb_reg, end_a,
                                IDX_W'(n_reg));

    assign sx = $signed(SUM_W'({va_reg[CRD_W-1], va_reg[CRD_W-1:0]}))
              + $signed(SUM_W'({vb_reg[CRD_W-1], vb_reg[CRD_W-1:0]}));
    assign sy = $signed(SUM_W'({va_reg[2*CRD_W-1], va_reg[2*CRD_W-1:CRD_W]}))
              + $signed(SUM_W'({vb_reg[2*CRD_W-1], vb_reg[2*CRD_W-1:CRD_W]}));
    assign sz = $signed(SUM_W'({va_reg[3*CRD_W-1], va_reg[3*CRD_W-1:2*CRD_W]}))
              + $signed(SUM_W'({vb_reg[3*CRD_W-1], vb_reg[3*CRD_W-1:2*CRD_W]}));

    smsub_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .sx    (sx),
        .sy    (sy),
        .sz    (sz),
        .done  (norm_done),
        .x     (nx),
        .y     (ny),
        .z     (nz)
    );

    // sub-triangles: (A,AB,CA) (AB,B,BC) (AB,BC,CA) (BC,C,CA)
    always_comb
    begin
        case (tri_cnt_reg)
            2'd0:
            begin
                tri_a = corner_reg[0];
                tri_b = mid_reg[0];
                tri_c = mid_reg[1];
            end
            2'd1:
            begin
                tri_a = mid_reg[0];
                tri_b = corner_reg[1];
                tri_c = mid_reg[2];
            end
            2'd2:
            begin
                tri_a = mid_reg[0];
                tri_b = mid_reg[2];
                tri_c = mid_reg[1];
            end
            default:
            begin
                tri_a = mid_reg[2];
                tri_b = corner_reg[2];
                tri_c = mid_reg[1];
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    // edge table: clear sweep, row write-back, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            emem[clr_cnt_reg] <= '0;
        end
        else if (cmd.row_wr)
        begin
            emem[end_sel[ADDR_W-1:0]] <= cmd.sel_b ? new_row_b : new_row_a;
        end
        erd_reg <= emem[end_sel[ADDR_W-1:0]];
    end

    // vertex store: loads and new midpoints share the write port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ld_ok)
        begin
            vmem[ld_index[ADDR_W-1:0]] <= {ld_z, ld_y, ld_x};
        end
        else if (cmd.row_wr && !cmd.sel_b)
        begin
            vmem[n_reg] <= {nz, ny, nx};
        end
        vrd_reg <= vmem[end_sel[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg        <= NV_W'(1);
            clr_cnt_reg   <= '0;
            edge_cnt_reg  <= '0;
            tri_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.nv_reset)
            begin
                nv_reg <= NV_W'(1);
            end
            else if (cmd.load_wr && ld_ok && (NV_W'(ld_index) + 1'b1 > nv_reg))
            begin
                nv_reg <= NV_W'(ld_index) + 1'b1;
            end
            else if (cmd.alloc)
            begin
                nv_reg <= nv_reg + 1'b1;
            end

            if (cmd.clr_start)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (cmd.tri_cap)
            begin
                edge_cnt_reg <= '0;
                tri_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.edge_next)
                begin
                    edge_cnt_reg <= edge_cnt_reg + 1'b1;
                end
                if (cmd.out_load && (cmd.out_kind == KIND_TRI))
                begin
                    tri_cnt_reg <= tri_cnt_reg + 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tri_cap)
        begin
            corner_reg[0] <= in_ca;
            corner_reg[1] <= in_cb;
            corner_reg[2] <= in_cc;
        end
        if (cmd.er_lat_a)
        begin
            row_a_reg <= erd_reg;
        end
        if (cmd.er_lat_b)
        begin
            row_b_reg <= erd_reg;
        end
        if (cmd.vr_lat_a)
        begin
            va_reg <= vrd_reg;
        end
        if (cmd.vr_lat_b)
        begin
            vb_reg <= vrd_reg;
        end
        if (cmd.take_mid)
        begin
            mid_reg[edge_cnt_reg] <= hit[IDX_W-1:0];
        end
        if (cmd.alloc)
        begin
            n_reg                 <= nv_reg[ADDR_W-1:0];
            fa_reg                <= fa[SLOT_W-1:0];
            fb_reg                <= fb[SLOT_W-1:0];
            mid_reg[edge_cnt_reg] <= IDX_W'(nv_reg[ADDR_W-1:0]);
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_idx_reg  <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_z_reg    <= '0;
            out_ta_reg   <= '0;
            out_tb_reg   <= '0;
            out_tc_reg   <= '0;
            out_err_reg  <= ERR_NONE;
            out_last_reg <= 1'b0;
            case (cmd.out_kind)
                KIND_VTX:
                begin
                    out_idx_reg <= IDX_W'(n_reg);
                    out_x_reg   <= nx;
                    out_y_reg   <= ny;
                    out_z_reg   <= nz;
                end
                KIND_TRI:
                begin
                    out_ta_reg   <= tri_a;
                    out_tb_reg   <= tri_b;
                    out_tc_reg   <= tri_c;
                    out_last_reg <= (tri_cnt_reg == 2'd3);
                end
                default:
                begin
                    out_err_reg  <= cmd.out_err;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == ADDR_W'(STORE_CAP - 1));
        stat.bad_corner = (in_ca == '0) || (NV_W'(in_ca) >= NV_W'(STORE_CAP))
                       || (in_cb == '0) || (NV_W'(in_cb) >= NV_W'(STORE_CAP))
                       || (in_cc == '0) || (NV_W'(in_cc) >= NV_W'(STORE_CAP));
        stat.found      = hit[IDX_W];
        stat.store_full = (nv_reg >= NV_W'(STORE_CAP));
        stat.slots_full = !fa[SLOT_W] || !fb[SLOT_W];
        stat.norm_done  = norm_done;
        stat.out_free   = out_free;
        stat.edge_last  = (edge_cnt_reg == 2'd2);
        stat.tri_last   = (tri_cnt_reg == 2'd3);
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {out_err_reg, out_tc_reg, out_tb_reg, out_ta_reg,
                        out_z_reg, out_y_reg, out_x_reg, out_idx_reg};

endmodule

// ----- sv/smsub_ctrl.sv -----
module smsub_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [smsub_pkg::USER_W-1:0]     in_user,
    input  smsub_pkg::stat_t                 stat,
    output smsub_pkg::cmd_t                  cmd
);
    import smsub_pkg::*;

    ctrl_state_t st_reg, st_next;
    action_t     act;

    assign act = action_t'(in_user);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLEAR:  if (stat.clr_last) st_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (act)
                        ACT_BEGIN, ACT_RESET: st_next = S_CLEAR;
                        ACT_TRI:  st_next = stat.bad_corner ? S_ERR_STORE : S_ERD_A;
                        default:  st_next = S_IDLE;
                    endcase
                end
            end
            S_ERD_A:  st_next = S_ERD_B;
            S_ERD_B:  st_next = S_ELAT;
            S_ELAT:   st_next = S_EVAL;
            S_EVAL:
            begin
                if (stat.found)
                begin
                    st_next = S_NEXT;
                end
                else if (stat.store_full)
                begin
                    st_next = S_ERR_STORE;
                end
                else if (stat.slots_full)
                begin
                    st_next = S_ERR_SLOT;
                end
                else
                begin
                    st_next = S_VRD_A;
                end
            end
            S_VRD_A:  st_next = S_VRD_B;
            S_VRD_B:  st_next = S_VLAT;
            S_VLAT:   st_next = S_NSTART;
            S_NSTART: st_next = S_NWAIT;
            S_NWAIT:  if (stat.norm_done) st_next = S_WR_A;
            S_WR_A:   st_next = S_WR_B;
            S_WR_B:   st_next = S_EMIT_V;
            S_EMIT_V: if (stat.out_free) st_next = S_NEXT;
            S_NEXT:   st_next = stat.edge_last ? S_EMIT_T : S_ERD_A;
            S_EMIT_T: if (stat.out_free && stat.tri_last) st_next = S_IDLE;
            S_ERR_SLOT, S_ERR_STORE:
            begin
                if (stat.out_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default:  st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (st_reg)
            S_CLEAR:  cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (act)
                        ACT_LOAD:  cmd.load_wr = 1'b1;
                        ACT_BEGIN: cmd.clr_start = 1'b1;
                        ACT_RESET:
                        begin
                            cmd.clr_start = 1'b1;
                            cmd.nv_reset  = 1'b1;
                        end
                        default:   cmd.tri_cap = 1'b1;
                    endcase
                end
            end
            S_ERD_A:  cmd.er_rd = 1'b1;
            S_ERD_B:
            begin
                cmd.er_rd    = 1'b1;
                cmd.sel_b    = 1'b1;
                cmd.er_lat_a = 1'b1;
            end
            S_ELAT:   cmd.er_lat_b = 1'b1;
            S_EVAL:
            begin
                if (stat.found)
                begin
                    cmd.take_mid = 1'b1;
                end
                else if (!stat.store_full && !stat.slots_full)
                begin
                    cmd.alloc = 1'b1;
                end
            end
            S_VRD_A:  cmd.vr_rd = 1'b1;
            S_VRD_B:
            begin
                cmd.vr_rd    = 1'b1;
                cmd.sel_b    = 1'b1;
                cmd.vr_lat_a = 1'b1;
            end
            S_VLAT:   cmd.vr_lat_b = 1'b1;
            S_NSTART: cmd.norm_start = 1'b1;
            S_WR_A:   cmd.row_wr = 1'b1;
            S_WR_B:
            begin
                cmd.row_wr = 1'b1;
                cmd.sel_b  = 1'b1;
            end
            S_EMIT_V:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = KIND_VTX;
            end
            S_NEXT:   cmd.edge_next = !stat.edge_last;
            S_EMIT_T:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = KIND_TRI;
            end
            S_ERR_SLOT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = KIND_ERR;
                cmd.out_err  = ERR_SLOTS;
            end
            S_ERR_STORE:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_kind = KIND_ERR;
                cmd.out_err  = ERR_STORE;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- sv/sphere_mesh_subdivider_top.sv -----
// Channel   Dir  tdata (low bit up)                                    tuser     tlast
// s_axis    in   load_index, load_x, load_y, load_z, corner_a/b/c, pad  action    -
// m_axis    out  new_index, new_x/y/z, tri_a/b/c, error_code           kind      last
//
// Begin pass and reset all start a sweep that clears every edge table row
// (one row per cycle); the same sweep runs after rst_n is released.
// Triangle: each edge is looked up in the table; a new midpoint also runs through
// the shared square-root and divide unit (squaring, square root, then one divide
// per coordinate), then the four triangle results follow.
// One item at a time; a held result stalls the sequencer only where it needs the
// output register. rst_n is asynchronous, active low.
module sphere_mesh_subdivider_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // load_index, load_x, load_y, load_z, corner_a, corner_b, corner_c, 2 zero bits
    input  logic [smsub_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [smsub_pkg::USER_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // new_index, new_x, new_y, new_z, tri_a, tri_b, tri_c, error_code
    output logic [smsub_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind
    output logic [smsub_pkg::USER_W-1:0]         m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import smsub_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: walks edges AB, CA, BC, then the four sub-triangles
    smsub_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_user  (s_axis_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, edge search, normalizer and the output register
    smsub_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- sv/smsub_checker.sv -----
`include "sphere_mesh_subdivider_top_assert.svh"

module smsub_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [smsub_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [smsub_pkg::USER_W-1:0]         m_axis_tuser,
    input logic                                 m_axis_tlast
);
    import smsub_pkg::*;

    `SMSUB_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result changed while stalled")
    `SMSUB_ASSERT_IMP(a_err_last, m_axis_tvalid && (m_axis_tuser == KIND_ERR),
        m_axis_tlast && (m_axis_tdata[103:102] != ERR_NONE), "error result malformed")
    `SMSUB_ASSERT_IMP(a_vtx_body, m_axis_tvalid && (m_axis_tuser == KIND_VTX),
        !m_axis_tlast && (m_axis_tdata[11:0] != '0), "vertex result malformed")
    `SMSUB_ASSERT_IMP(a_kind_ok, m_axis_tvalid,
        (m_axis_tuser == KIND_VTX) || (m_axis_tuser == KIND_TRI)
        || (m_axis_tuser == KIND_ERR), "unknown result kind")

endmodule

bind sphere_mesh_subdivider_top smsub_checker u_chk (.*);

// ----- verif/tb_sphere_mesh_subdivider_top.sv -----
`timescale 1ns / 1ps

module tb_sphere_mesh_subdivider_top;
    import smsub_pkg::*;

    localparam int CAP       = 4096;
    localparam int SLOTS     = 6;
    localparam int IDLE_MAX  = 20000;   // cycles with no transfer on either side
    localparam int TAIL      = 600;     // settle time once nothing is expected
    localparam int RAND_ITEMS = 140;

    // One input item, fields as the block sees them.
    typedef struct packed {
        action_t           act;
        logic [11:0]       load_idx;
        logic signed [17:0] lx;
        logic signed [17:0] ly;
        logic signed [17:0] lz;
        logic [11:0]       ca;
        logic [11:0]       cb;
        logic [11:0]       cc;
    } mesh_item_t;

    // One result item.
    typedef struct packed {
        kind_t             kind;
        logic [11:0]       vidx;
        logic signed [17:0] vx;
        logic signed [17:0] vy;
        logic signed [17:0] vz;
        logic [11:0]       ta;
        logic [11:0]       tb;
        logic [11:0]       tc;
        err_t              err;
        logic              last;
    } mesh_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    always #5 clk = ~clk;

    sphere_mesh_subdivider_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Mesh predictor: own copy of vertex store, edge table, next index.
    // ------------------------------------------------------------------
    int          mesh_x [CAP];
    int          mesh_y [CAP];
    int          mesh_z [CAP];
    logic [11:0] mesh_nb  [CAP][SLOTS];
    logic [11:0] mesh_mid [CAP][SLOTS];
    int          next_free;

    mesh_item_t  pending_items[$];
    mesh_res_t   expected_results[$];

    int mismatches = 0;
    int idle_cycles = 0;

    function automatic void clear_edges();
        for (int i = 0; i < CAP; i++)
            for (int j = 0; j < SLOTS; j++)
            begin
                mesh_nb[i][j]  = '0;
                mesh_mid[i][j] = '0;
            end
    endfunction

    function automatic void clear_mesh();
        for (int i = 0; i < CAP; i++)
        begin
            mesh_x[i] = 0;
            mesh_y[i] = 0;
            mesh_z[i] = 0;
        end
        clear_edges();
        next_free = 1;
    endfunction

    function automatic void push_result(kind_t k, int idx, int x, int y, int z,
                                        int a, int b, int c, err_t e, bit lst);
        mesh_res_t r;
        r.kind = k;
        r.vidx = idx[11:0];
        r.vx   = x[17:0];
        r.vy   = y[17:0];
        r.vz   = z[17:0];
        r.ta   = a[11:0];
        r.tb   = b[11:0];
        r.tc   = c[11:0];
        r.err  = e;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Scale one coordinate of the endpoint sum onto the unit sphere.
    function automatic int scale_axis(longint s, longint unsigned r);
        longint unsigned mag = (s < 0) ? longint'(-s) : longint'(s);
        longint unsigned num = mag << (FRAC_BITS + 12);
        longint unsigned q = (2 * num + r) / (2 * r);
        if (s < 0)
            return (q > 131072) ? -131072 : -int'(q);
        return (q > 131071) ? 131071 : int'(q);
    endfunction

    function automatic void norm_midpoint(int a, int b, output int rx, output int ry,
                                          output int rz);
        longint sx = longint'(mesh_x[a]) + mesh_x[b];
        longint sy = longint'(mesh_y[a]) + mesh_y[b];
        longint sz = longint'(mesh_z[a]) + mesh_z[b];
        longint unsigned n2 = sx * sx + sy * sy + sz * sz;
        longint unsigned r;
        if (n2 == 0)
        begin
            rx = 0; ry = 0; rz = 0;
            return;
        end
        r = int_sqrt(n2 << 24);
        rx = scale_axis(sx, r);
        ry = scale_axis(sy, r);
        rz = scale_axis(sz, r);
    endfunction

    function automatic int first_free(int row, int skip);
        for (int i = 0; i < SLOTS; i++)
            if (mesh_nb[row][i] == 0 && i != skip)
                return i;
        return -1;
    endfunction

    // Midpoint index of edge (a,b), creating it if missing; negative is an error code.
    function automatic int edge_midpoint(int a, int b);
        int fa, fb, n, x, y, z;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (mesh_nb[a][i] == b)
                return mesh_mid[a][i];
            if (mesh_nb[b][i] == a)
                return mesh_mid[b][i];
        end
        if (next_free >= CAP)
            return -int'(ERR_STORE);
        fa = first_free(a, -1);
        fb = (fa < 0) ? -1 : first_free(b, (a == b) ? fa : -1);
        if (fa < 0 || fb < 0)
            return -int'(ERR_SLOTS);
        n = next_free;
        next_free++;
        norm_midpoint(a, b, x, y, z);
        mesh_x[n] = x;
        mesh_y[n] = y;
        mesh_z[n] = z;
        mesh_nb[a][fa]  = b[11:0];
        mesh_mid[a][fa] = n[11:0];
        mesh_nb[b][fb]  = a[11:0];
        mesh_mid[b][fb] = n[11:0];
        push_result(KIND_VTX, n, x, y, z, 0, 0, 0, ERR_NONE, 1'b0);
        return n;
    endfunction

    function automatic void predict_item(mesh_item_t it);
        // corner positions: 0..2 = A,B,C, 3 = AB, 4 = BC, 5 = CA
        int sub_pos [4][3] = '{'{0, 3, 5}, '{3, 1, 4}, '{3, 4, 5}, '{4, 2, 5}};
        int end_a [6] = '{0, 1, 2, 0, 1, 2};
        int end_b [6] = '{0, 1, 2, 1, 2, 0};
        int c [3];
        int tris [4][3];
        int p, m;
        case (it.act)
            ACT_RESET: clear_mesh();
            ACT_BEGIN: clear_edges();
            ACT_LOAD:
            begin
                if (it.load_idx != 0)
                begin
                    mesh_x[it.load_idx] = it.lx;
                    mesh_y[it.load_idx] = it.ly;
                    mesh_z[it.load_idx] = it.lz;
                    if (int'(it.load_idx) + 1 > next_free)
                        next_free = int'(it.load_idx) + 1;
                end
            end
            default:
            begin
                c[0] = it.ca;
                c[1] = it.cb;
                c[2] = it.cc;
                if (c[0] == 0 || c[1] == 0 || c[2] == 0)
                begin
                    push_result(KIND_ERR, 0, 0, 0, 0, 0, 0, 0, ERR_STORE, 1'b1);
                    return;
                end
                for (int n = 0; n < 4; n++)
                    for (int i = 0; i < 3; i++)
                    begin
                        p = sub_pos[n][i];
                        if (end_a[p] == end_b[p])
                            tris[n][i] = c[end_a[p]];
                        else
                        begin
                            m = edge_midpoint(c[end_a[p]], c[end_b[p]]);
                            if (m < 0)
                            begin
                                push_result(KIND_ERR, 0, 0, 0, 0, 0, 0, 0, err_t'(-m), 1'b1);
                                return;
                            end
                            tris[n][i] = m;
                        end
                    end
                for (int n = 0; n < 4; n++)
                    push_result(KIND_TRI, 0, 0, 0, 0, tris[n][0], tris[n][1], tris[n][2],
                                ERR_NONE, n == 3);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    int loaded[$];   // indices written since the last reset all, for corner picks

    function automatic void add_item(action_t act, int idx, int x, int y, int z,
                                     int a, int b, int c);
        mesh_item_t it;
        it.act = act;
        it.load_idx = idx[11:0];
        it.lx = x[17:0];
        it.ly = y[17:0];
        it.lz = z[17:0];
        it.ca = a[11:0];
        it.cb = b[11:0];
        it.cc = c[11:0];
        pending_items.push_back(it);
        if (act == ACT_RESET)
            loaded.delete();
        if (act == ACT_LOAD && idx != 0)
            loaded.push_back(idx);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    function automatic int pick_corner();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps.
    // ------------------------------------------------------------------
    mesh_item_t cur_item;
    bit have_item = 0;
    bit item_sent = 0;
    int gap_left = 0;
    int burst_left = 1;

    always @(negedge clk)
    begin
        if (item_sent)
        begin
            item_sent = 0;
            have_item = 0;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
        end
        if (!have_item && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                have_item = 1;
            end
        end
        s_axis_tvalid <= have_item;
        s_axis_tdata  <= {2'b00, cur_item.cc, cur_item.cb, cur_item.ca,
                          cur_item.lz, cur_item.ly, cur_item.lx, cur_item.load_idx};
        s_axis_tuser  <= cur_item.act;
    end

    // Receiver: ready pattern switches among always-ready, random and mostly-low modes.
    int rx_mode = 0;
    int rx_cnt = 0;

    always @(negedge clk)
    begin
        rx_cnt++;
        if (rx_cnt % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (rx_cnt % 16) < 3;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mesh_res_t got, want;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                item_sent = 1;
                idle_cycles = 0;
                predict_item(cur_item);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                got.kind = kind_t'(m_axis_tuser);
                got.vidx = m_axis_tdata[11:0];
                got.vx   = m_axis_tdata[29:12];
                got.vy   = m_axis_tdata[47:30];
                got.vz   = m_axis_tdata[65:48];
                got.ta   = m_axis_tdata[77:66];
                got.tb   = m_axis_tdata[89:78];
                got.tc   = m_axis_tdata[101:90];
                got.err  = err_t'(m_axis_tdata[103:102]);
                got.last = m_axis_tlast;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.vidx !== want.vidx ||
                        got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                        got.ta !== want.ta || got.tb !== want.tb || got.tc !== want.tc ||
                        got.err !== want.err || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h, actual %h", want, got);
                    end
                end
            end
            // watchdog: no transfer on either side for too long
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("sphere_mesh_subdivider_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int count, nl, nt, a, b, c, idx;
        clear_mesh();

        // Directed: extreme axes, zero-length sum, edge reuse, bad corner,
        // full neighbor slots, degenerate edge, full store, ignored load.
        add_item(ACT_LOAD, 1, 65536, 0, 0, 0, 0, 0);
        add_item(ACT_LOAD, 2, 0, 65536, 0, 0, 0, 0);
        add_item(ACT_LOAD, 3, 0, 0, 65536, 0, 0, 0);
        add_item(ACT_LOAD, 4, -65536, 0, 0, 0, 0, 0);
        add_item(ACT_LOAD, 5, 0, -65536, 0, 0, 0, 0);
        add_item(ACT_LOAD, 6, 0, 0, -65536, 0, 0, 0);
        add_item(ACT_LOAD, 40, 37837, -37837, 37837, 0, 0, 0);
        add_item(ACT_LOAD, 41, -1, 1, -65535, 0, 0, 0);
        add_item(ACT_LOAD, 0, 123, 456, 789, 0, 0, 0);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 2, 3);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 2, 3);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 4, 5);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 6, 40);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 41, 2);
        add_item(ACT_TRI, 0, 0, 0, 0, 0, 1, 2);
        add_item(ACT_TRI, 0, 0, 0, 0, 2, 3, 0);
        add_item(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_TRI, 0, 0, 0, 0, 3, 3, 3);
        add_item(ACT_LOAD, 4095, -65536, 65536, -65536, 0, 0, 0);
        add_item(ACT_TRI, 0, 0, 0, 0, 1, 2, 3);
        add_item(ACT_TRI, 0, 0, 0, 0, 4095, 3, 3);
        add_item(ACT_RESET, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_LOAD, 7, 1, 2, 3, 0, 0, 0);
        add_item(ACT_TRI, 0, 0, 0, 0, 7, 7, 7);

        // Random sessions: load a handful, usually begin a pass, split triangles on them.
        count = 0;
        while (count < RAND_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                add_item(ACT_RESET, 0, 0, 0, 0, 0, 0, 0);
                count++;
            end
            nl = $urandom_range(2, 6);
            for (int i = 0; i < nl; i++)
            begin
                case ($urandom_range(0, 9))
                    0: idx = $urandom_range(1, 4095);
                    1: idx = 0;
                    default: idx = $urandom_range(1, 60);
                endcase
                add_item(ACT_LOAD, idx, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
                count++;
            end
            if (loaded.size() == 0)
                continue;
            if ($urandom_range(0, 2) != 0)
            begin
                add_item(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0);
                count++;
            end
            nt = $urandom_range(3, 8);
            for (int i = 0; i < nt; i++)
            begin
                a = pick_corner();
                b = pick_corner();
                c = pick_corner();
                if ($urandom_range(0, 15) == 0)
                    a = 0;
                add_item(ACT_TRI, 0, 0, 0, 0, a, b, c);
                count++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || have_item || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("sphere_mesh_subdivider_top: match");
        else
            $display("sphere_mesh_subdivider_top: mismatch");
        $finish;
    end

endmodule
